// ===== src/cac_pkg.sv =====
package cac_pkg;

  // field widths
  localparam int MW   = 20;        // momentum component
  localparam int PW   = 24;        // position / offset component
  localparam int P2W  = 40;        // |p|^2
  localparam int DOTW = 45;        // p . r, signed
  localparam int ADW  = 44;        // |p . r|
  localparam int NW   = 63;        // |p . r| * |p_i|
  localparam int QW   = 25;        // projection quotient bits (one per divider stage)
  localparam int RMW  = P2W + 1;   // divider partial remainder
  localparam int DW   = 27;        // unsaturated offset component, signed
  localparam int SQW  = 56;        // sum of squares
  localparam int RTW  = SQW / 2;   // square root bits (one per root stage)
  localparam int SRW  = RTW + 3;   // root partial remainder

  localparam logic [PW-1:0] SAT_POS = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] SAT_NEG = {1'b1, {(PW-1){1'b0}}};
  localparam logic [PW-1:0] LEN_MAX = {PW{1'b1}};

endpackage

// ===== src/closest_approach_to_origin_unit.sv =====
// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// item     | item_valid / item_stall    | apply_projection, mom_x/y/z, pos_x/y/z
// result   | result_valid / result_stall| dca_len, dca_x/y/z, zero_momentum
//
// One transaction enters per cycle while item_stall is low; results leave in the
// order in which their items were accepted.
// The pipeline holds the 25-stage restoring divider (one quotient bit per stage)
// and the 28-stage square root (one root bit per stage).
// rst is synchronous and clears only the stage valid bits.
// A result_stall held while result_valid is high freezes the whole pipeline;
// item_stall follows it, so nothing is dropped or repeated.
module closest_approach_to_origin_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             apply_projection,
  input  logic signed [cac_pkg::MW-1:0]    mom_x,
  input  logic signed [cac_pkg::MW-1:0]    mom_y,
  input  logic signed [cac_pkg::MW-1:0]    mom_z,
  input  logic signed [cac_pkg::PW-1:0]    pos_x,
  input  logic signed [cac_pkg::PW-1:0]    pos_y,
  input  logic signed [cac_pkg::PW-1:0]    pos_z,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic        [cac_pkg::PW-1:0]    dca_len,
  output logic signed [cac_pkg::PW-1:0]    dca_x,
  output logic signed [cac_pkg::PW-1:0]    dca_y,
  output logic signed [cac_pkg::PW-1:0]    dca_z,
  output logic                             zero_momentum
);
  import cac_pkg::*;

  // global advance: the pipeline moves unless a finished result is held off
  logic adv;
  assign adv        = !(result_valid && result_stall);
  assign item_stall = !adv;

  // ---- stage A: input capture
  logic                 a_vld, a_kill;
  logic signed [MW-1:0] a_p [3];
  logic signed [PW-1:0] a_r [3];

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (adv) a_vld <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kill <= !apply_projection;
      a_p[0] <= mom_x;
      a_p[1] <= mom_y;
      a_p[2] <= mom_z;
      a_r[0] <= pos_x;
      a_r[1] <= pos_y;
      a_r[2] <= pos_z;
    end
  end

  // ---- stage B: component products
  logic                   b_vld, b_kill;
  logic signed [PW+MW-1:0] b_pr [3];
  logic        [P2W-2:0]  b_pp [3];
  logic        [MW-1:0]   b_pmag [3];
  logic                   b_pneg [3];
  logic signed [PW-1:0]   b_r [3];

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (adv) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_kill <= a_kill;
      for (int i = 0; i < 3; i++) begin
        b_pr[i]   <= a_p[i] * a_r[i];
        b_pp[i]   <= (P2W-1)'(a_p[i]) * (P2W-1)'(a_p[i]);
        b_pmag[i] <= a_p[i][MW-1] ? MW'(-a_p[i]) : MW'(a_p[i]);
        b_pneg[i] <= a_p[i][MW-1];
        b_r[i]    <= a_r[i];
      end
    end
  end

  // ---- stage C: |p|^2 and p . r
  logic                   c_vld, c_kill;
  logic        [P2W-1:0]  c_p2;
  logic signed [DOTW-1:0] c_dot;
  logic        [MW-1:0]   c_pmag [3];
  logic                   c_pneg [3];
  logic signed [PW-1:0]   c_r [3];

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (adv) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_kill <= b_kill;
      c_p2   <= P2W'(b_pp[0]) + P2W'(b_pp[1]) + P2W'(b_pp[2]);
      c_dot  <= DOTW'(b_pr[0]) + DOTW'(b_pr[1]) + DOTW'(b_pr[2]);
      c_pmag <= b_pmag;
      c_pneg <= b_pneg;
      c_r    <= b_r;
    end
  end

  // ---- stage D / divider stage 0: numerators |p.r| * |p_i|
  logic [ADW-1:0] c_dmag;
  logic           c_dneg, c_pzero;
  assign c_dneg  = c_dot[DOTW-1];
  assign c_dmag  = c_dneg ? ADW'(-c_dot) : ADW'(c_dot);
  assign c_pzero = (c_p2 == '0);

  logic                 dv_vld  [QW+1];
  logic                 dv_kill [QW+1];
  logic                 dv_zm   [QW+1];
  logic [P2W-1:0]       dv_p2   [QW+1];
  logic [RMW-1:0]       dv_rem  [QW+1][3];
  logic [QW-1:0]        dv_low  [QW+1][3];
  logic [QW-1:0]        dv_q    [QW+1][3];
  logic                 dv_neg  [QW+1][3];
  logic signed [PW-1:0] dv_r    [QW+1][3];
  logic [NW-1:0]        c_num   [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_num[i] = NW'({20'd0, c_dmag} * {{ADW{1'b0}}, c_pmag[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (adv) dv_vld[0] <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_kill[0] <= c_kill | c_pzero;
      dv_zm[0]   <= !c_kill & c_pzero;
      dv_p2[0]   <= c_p2;
      for (int i = 0; i < 3; i++) begin
        // quotient is known to stay below 2^QW, so the top bits start below |p|^2
        dv_rem[0][i] <= RMW'(c_num[i][NW-1:QW]);
        dv_low[0][i] <= c_num[i][QW-1:0];
        dv_q[0][i]   <= '0;
        dv_neg[0][i] <= c_dneg ^ c_pneg[i];
        dv_r[0][i]   <= c_r[i];
      end
    end
  end

  // ---- divider stages: one quotient bit each, three lanes
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RMW-1:0] t  [3];
    logic           ge [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {dv_rem[k][i][RMW-2:0], dv_low[k][i][QW-1]};
        ge[i] = (t[i] >= {1'b0, dv_p2[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else if (adv) dv_vld[k+1] <= dv_vld[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_kill[k+1] <= dv_kill[k];
        dv_zm[k+1]   <= dv_zm[k];
        dv_p2[k+1]   <= dv_p2[k];
        for (int i = 0; i < 3; i++) begin
          dv_rem[k+1][i] <= ge[i] ? t[i] - {1'b0, dv_p2[k]} : t[i];
          dv_low[k+1][i] <= {dv_low[k][i][QW-2:0], 1'b0};
          dv_q[k+1][i]   <= {dv_q[k][i][QW-2:0], ge[i]};
          dv_neg[k+1][i] <= dv_neg[k][i];
          dv_r[k+1][i]   <= dv_r[k][i];
        end
      end
    end
  end

  // ---- stage E: round half away from zero, apply sign, subtract from r
  logic                 e_vld, e_kill, e_zm;
  logic signed [DW-1:0] e_d [3];
  logic        [QW:0]   e_qr [3];
  logic signed [DW-1:0] e_proj [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_qr[i]   = (QW+1)'(dv_q[QW][i]) +
                  (QW+1)'({dv_rem[QW][i][RMW-2:0], 1'b0} >= {1'b0, dv_p2[QW]});
      e_proj[i] = dv_neg[QW][i] ? -DW'(e_qr[i]) : DW'(e_qr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (adv) e_vld <= dv_vld[QW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_kill <= dv_kill[QW];
      e_zm   <= dv_zm[QW];
      for (int i = 0; i < 3; i++) begin
        e_d[i] <= DW'(dv_r[QW][i]) - e_proj[i];
      end
    end
  end

  // ---- stage F: squares and saturated components
  logic                  f_vld, f_kill, f_zm;
  logic [2*DW-1:0]       f_sq  [3];
  logic [PW-1:0]         f_sat [3];
  logic [DW-1:0]         e_dmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_dmag[i] = e_d[i][DW-1] ? DW'(-e_d[i]) : DW'(e_d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (adv) f_vld <= e_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_kill <= e_kill;
      f_zm   <= e_zm;
      for (int i = 0; i < 3; i++) begin
        f_sq[i] <= (2*DW)'(e_dmag[i]) * (2*DW)'(e_dmag[i]);
        if (e_d[i] > DW'($signed(SAT_POS)))       f_sat[i] <= SAT_POS;
        else if (e_d[i] < DW'($signed(SAT_NEG)))  f_sat[i] <= SAT_NEG;
        else                                      f_sat[i] <= e_d[i][PW-1:0];
      end
    end
  end

  // ---- stage G / root stage 0: sum of squares
  logic           sq_vld  [RTW+1];
  logic           sq_kill [RTW+1];
  logic           sq_zm   [RTW+1];
  logic [SQW-1:0] sq_val  [RTW+1];
  logic [SRW-1:0] sq_rem  [RTW+1];
  logic [RTW-1:0] sq_root [RTW+1];
  logic [PW-1:0]  sq_d    [RTW+1][3];

  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (adv) sq_vld[0] <= f_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_kill[0] <= f_kill;
      sq_zm[0]   <= f_zm;
      sq_val[0]  <= SQW'(f_sq[0]) + SQW'(f_sq[1]) + SQW'(f_sq[2]);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_d[0]    <= f_sat;
    end
  end

  // ---- root stages: one root bit each, digit pair from the top
  for (genvar k = 0; k < RTW; k++) begin : g_root
    logic [SRW-1:0] rv, trial;
    logic           ge;

    always_comb begin
      rv    = {sq_rem[k][SRW-3:0], sq_val[k][SQW-1:SQW-2]};
      trial = SRW'({sq_root[k], 2'b01});
      ge    = (rv >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) sq_vld[k+1] <= 1'b0;
      else if (adv) sq_vld[k+1] <= sq_vld[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_kill[k+1] <= sq_kill[k];
        sq_zm[k+1]   <= sq_zm[k];
        sq_val[k+1]  <= {sq_val[k][SQW-3:0], 2'b00};
        sq_rem[k+1]  <= ge ? rv - trial : rv;
        sq_root[k+1] <= {sq_root[k][RTW-2:0], ge};
        sq_d[k+1]    <= sq_d[k];
      end
    end
  end

  // ---- output register: length saturation and forced-zero cases
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= sq_vld[RTW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_momentum <= sq_zm[RTW];
      if (sq_kill[RTW]) begin
        dca_len <= '0;
        dca_x   <= '0;
        dca_y   <= '0;
        dca_z   <= '0;
      end else begin
        dca_len <= (|sq_root[RTW][RTW-1:PW]) ? LEN_MAX : sq_root[RTW][PW-1:0];
        dca_x   <= sq_d[RTW][0];
        dca_y   <= sq_d[RTW][1];
        dca_z   <= sq_d[RTW][2];
      end
    end
  end

endmodule
